>>> rtl/core/psd_pkg.sv
package psd_pkg;

    localparam int FRAC_BITS    = 8;
    localparam int NEWTON_STEPS = 10;
    localparam int ACC_BITS     = 64;
    localparam int OUT_BITS     = 24;
    localparam int CNT_OUT_BITS = 13;

    // Sample handed from the front to the back part.
    typedef struct packed {
        logic        last;
        logic [31:0] sample;
    } t_entry;

    // Divider request and answer.
    typedef struct packed {
        logic                  start;
        logic [ACC_BITS-1:0]   num;
        logic [ACC_BITS-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [ACC_BITS-1:0]   quo;
    } t_div_rsp;

endpackage

>>> rtl/core/psd_fifo.sv
module psd_fifo #(
    parameter int DEPTH_BITS = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  psd_pkg::t_entry i_data,
    input  logic            i_pop,
    output psd_pkg::t_entry o_data,
    output logic            o_empty,
    output logic            o_full
);
    localparam int DEPTH = 1 << DEPTH_BITS;

    psd_pkg::t_entry         r_mem [DEPTH];
    logic [DEPTH_BITS-1:0]   r_wp, r_rp;
    logic [DEPTH_BITS:0]     r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (DEPTH_BITS+1)'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (DEPTH_BITS+1)'(i_push) - (DEPTH_BITS+1)'(i_pop);
        end
    end
endmodule

>>> rtl/core/psd_div.sv
module psd_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  psd_pkg::t_div_req i_req,
    output psd_pkg::t_div_rsp o_rsp
);
    localparam int W = psd_pkg::ACC_BITS;

    logic [W-1:0]         r_quo, r_den;
    logic [W:0]           r_rem;
    logic [$clog2(W):0]   r_cnt;
    logic                 r_busy, r_done;
    logic [W:0]           n_rem;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        n_rem = {r_rem[W-1:0], r_quo[W-1]};
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (n_rem >= {1'b0, r_den}) begin
                    r_rem <= n_rem - {1'b0, r_den};
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(W)+1)'(W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

>>> rtl/core/psd_back.sv
module psd_back #(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  psd_pkg::t_entry                  i_entry,
    output logic                             o_pop,
    output logic                             o_valid,
    output logic [psd_pkg::OUT_BITS-1:0]     o_std_dev,
    output logic                             o_saturated,
    output logic [psd_pkg::CNT_OUT_BITS-1:0] o_sample_count
);
    localparam int W  = psd_pkg::ACC_BITS;
    localparam int AB = $clog2(MAX_SAMPLES);
    localparam int CB = $clog2(MAX_SAMPLES + 1);
    localparam logic [W-1:0] ONES = '1;

    typedef enum logic [3:0] {
        S_LOAD, S_MEAN, S_MEANW, S_RD, S_SQ, S_ACC, S_VAR, S_VARW,
        S_NEWT, S_NEWTW, S_OUT
    } t_state;

    t_state                r_state;
    logic [SAMPLE_BITS-1:0] r_mem [MAX_SAMPLES];
    logic [SAMPLE_BITS-1:0] r_rd;
    logic [CB-1:0]          r_cnt, r_idx;
    logic [W-1:0]           r_sum, r_mean, r_dsum, r_d, r_sq, r_v, r_x, r_num;
    logic [3:0]             r_step;
    psd_pkg::t_div_req      r_req;
    psd_pkg::t_div_rsp      w_rsp;
    logic [W-1:0]           w_xs, w_nx;
    logic [W:0]             w_add;
    logic [W-1:0]           w_root;

    psd_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_req), .o_rsp(w_rsp)
    );

    assign o_pop  = (r_state == S_LOAD) && i_valid;
    assign w_xs   = W'(r_rd) << psd_pkg::FRAC_BITS;
    assign w_add  = {1'b0, r_x >> 1} + {1'b0, (r_x == '0) ? ONES : w_rsp.quo};
    assign w_nx   = w_add[W] ? ONES : w_add[W-1:0];
    assign w_root = r_x >> psd_pkg::FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (o_pop && r_cnt < CB'(MAX_SAMPLES))
            r_mem[r_cnt[AB-1:0]] <= i_entry.sample[SAMPLE_BITS-1:0];
        r_rd <= r_mem[r_idx[AB-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_dsum  <= '0;
            r_idx   <= '0;
            r_req   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            o_valid     <= 1'b0;
            case (r_state)
                S_LOAD: if (o_pop) begin
                    if (r_cnt < CB'(MAX_SAMPLES)) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_sum <= r_sum + W'(i_entry.sample[SAMPLE_BITS-1:0]);
                    end
                    if (i_entry.last) r_state <= S_MEAN;
                end
                S_MEAN: begin
                    r_req <= '{start: 1'b1, num: r_sum << psd_pkg::FRAC_BITS, den: W'(r_cnt)};
                    r_state <= S_MEANW;
                end
                S_MEANW: if (w_rsp.done) begin
                    r_mean  <= w_rsp.quo;
                    r_idx   <= '0;
                    r_dsum  <= '0;
                    r_state <= S_RD;
                end
                S_RD: r_state <= S_SQ;          // wait for registered read
                S_SQ: begin
                    r_d     <= (w_xs >= r_mean) ? w_xs - r_mean : r_mean - w_xs;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sq   <= (r_d > W'(32'hFFFF_FFFF)) ? ONES
                              : W'(r_d[31:0]) * W'(r_d[31:0]);
                    r_state <= S_VAR;
                end
                S_VAR: begin
                    // accumulate, advance or divide
                    begin
                        logic [W:0] s;
                        s = {1'b0, r_dsum} + {1'b0, r_sq};
                        r_dsum <= s[W] ? ONES : s[W-1:0];
                    end
                    if (r_idx + 1'b1 < r_cnt) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_VARW;
                        r_req.start <= 1'b0;
                        r_idx <= '0;
                    end
                end
                S_VARW: begin
                    if (!r_idx[0]) begin
                        r_req   <= '{start: 1'b1, num: r_dsum, den: W'(r_cnt)};
                        r_idx   <= CB'(1);
                    end else if (w_rsp.done) begin
                        r_v    <= w_rsp.quo;
                        r_x    <= w_rsp.quo;
                        r_num  <= (w_rsp.quo > (ONES >> 15)) ? ONES : w_rsp.quo << 15;
                        r_step <= '0;
                        r_state <= (w_rsp.quo == '0) ? S_OUT : S_NEWT;
                    end
                end
                S_NEWT: begin
                    r_req   <= '{start: 1'b1, num: r_num, den: r_x};
                    r_state <= S_NEWTW;
                end
                S_NEWTW: if (w_rsp.done) begin
                    r_x <= w_nx;
                    if (r_step == 4'(psd_pkg::NEWTON_STEPS - 1)) r_state <= S_OUT;
                    else begin
                        r_step  <= r_step + 1'b1;
                        r_state <= S_NEWT;
                    end
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    if (r_v == '0) begin
                        o_std_dev   <= '0;
                        o_saturated <= 1'b0;
                    end else if (w_root > W'(24'hFF_FFFF)) begin
                        o_std_dev   <= '1;
                        o_saturated <= 1'b1;
                    end else begin
                        o_std_dev   <= w_root[psd_pkg::OUT_BITS-1:0];
                        o_saturated <= 1'b0;
                    end
                    o_sample_count <= psd_pkg::CNT_OUT_BITS'(r_cnt);
                    r_cnt   <= '0;
                    r_sum   <= '0;
                    r_dsum  <= '0;
                    r_state <= S_LOAD;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule

>>> rtl/core/population_std_deviation_top.sv
// Population standard deviation of a streamed data set. Drive start with
// one sample per cycle (busy low); i_last closes the set. Samples past
// MAX_SAMPLES are dropped, but a last mark on them still closes the set.
// After the last sample the block computes the mean with a 64-bit divider,
// walks the stored set again (read, difference, square and accumulate per
// sample), divides once more, then runs ten Newton steps of one divide each.
// o_valid pulses for one cycle with the Q16.8 result; the receiver cannot
// stall it. busy stays high while a set is being computed.
module population_std_deviation_top #(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_last,
    output logic                   o_valid,
    output logic [23:0]            o_std_dev,
    output logic                   o_saturated,
    output logic [12:0]            o_sample_count
);
    psd_pkg::t_entry w_in, w_head;
    logic            w_empty, w_full, w_pop, w_push;
    logic            r_closed;

    // Front: take items into the queue; hold off after a last mark until
    // the back part returns to loading.
    assign busy   = w_full || r_closed;
    assign w_push = start && !busy;
    assign w_in   = '{last: i_last, sample: 32'(i_sample)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_closed <= 1'b0;
        else if (w_push && i_last) r_closed <= 1'b1;
        else if (o_valid) r_closed <= 1'b0;
    end

    psd_fifo #(.DEPTH_BITS(2)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_data(w_in),
        .i_pop(w_pop), .o_data(w_head), .o_empty(w_empty), .o_full(w_full)
    );

    psd_back #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(!w_empty), .i_entry(w_head),
        .o_pop(w_pop), .o_valid(o_valid), .o_std_dev(o_std_dev),
        .o_saturated(o_saturated), .o_sample_count(o_sample_count)
    );
endmodule

>>> tb/sv/population_std_deviation_top_test.sv
module population_std_deviation_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SAMPLES = 4096;
    localparam int SAMPLE_BITS = 16;

    // One expected result of a closed data set.
    typedef struct {
        logic [23:0] std_dev;
        logic        saturated;
        logic [12:0] sample_count;
    } t_stddev_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [SAMPLE_BITS-1:0] i_sample;
    logic                   i_last;
    logic                   o_valid;
    logic [23:0]            o_std_dev;
    logic                   o_saturated;
    logic [12:0]            o_sample_count;

    population_std_deviation_top #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_sample(i_sample),
        .i_last(i_last),
        .o_valid(o_valid),
        .o_std_dev(o_std_dev),
        .o_saturated(o_saturated),
        .o_sample_count(o_sample_count)
    );

    // Predictor state: the samples of the set being loaded.
    logic [15:0]    set_samples[MAX_SAMPLES];
    logic [63:0]    set_sum;
    int unsigned    set_count;
    t_stddev_result pending_results[$];
    int             errors;
    int             idle_pct;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    // Close the set: mean, squared deviations, variance, ten Newton steps.
    function automatic t_stddev_result close_set();
        t_stddev_result r;
        logic [63:0] mean, dev_acc, var_q16, x, num, q, xs, d, root;
        mean = (set_sum << 8) / set_count;
        dev_acc = '0;
        for (int i = 0; i < set_count; i++) begin
            xs = {40'd0, set_samples[i], 8'd0};
            d = (xs >= mean) ? xs - mean : mean - xs;
            dev_acc = add_sat(dev_acc, (d > 64'hFFFF_FFFF) ? '1 : d * d);
        end
        var_q16 = dev_acc / set_count;
        r.std_dev = '0;
        r.saturated = 1'b0;
        r.sample_count = set_count[12:0];
        if (var_q16 != 0) begin
            x = var_q16;
            num = (var_q16 > (64'hFFFF_FFFF_FFFF_FFFF >> 15)) ? '1 : var_q16 << 15;
            for (int s = 0; s < 10; s++) begin
                q = (x != 0) ? num / x : '1;
                x = add_sat(x >> 1, q);
            end
            root = x >> 8;
            if (root > 64'hFF_FFFF) begin
                r.std_dev = '1;
                r.saturated = 1'b1;
            end else begin
                r.std_dev = root[23:0];
            end
        end
        set_sum = '0;
        set_count = 0;
        return r;
    endfunction

    // Send one item; hold start until the block takes it.
    task automatic send_sample(logic [15:0] s, logic last);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_sample <= s;
        i_last <= last;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        // Accepted at this edge; advance the predictor.
        if (set_count < MAX_SAMPLES) begin
            set_samples[set_count] = s;
            set_sum += s;
            set_count++;
        end
        if (last) pending_results.push_back(close_set());
    endtask

    // Check each strobed result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result std_dev=%0d", o_std_dev);
                errors++;
            end else begin
                t_stddev_result e;
                e = pending_results.pop_front();
                if (o_std_dev !== e.std_dev) begin
                    $error("std_dev expected %0d actual %0d", e.std_dev, o_std_dev);
                    errors++;
                end
                if (o_saturated !== e.saturated) begin
                    $error("saturated expected %0d actual %0d", e.saturated, o_saturated);
                    errors++;
                end
                if (o_sample_count !== e.sample_count) begin
                    $error("sample_count expected %0d actual %0d",
                           e.sample_count, o_sample_count);
                    errors++;
                end
            end
        end
    end

    // Drop start and wait until every expected result has come.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Random sample, biased toward the extremes.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_sample(16'h1234, 1'b1);           // single sample: zero variance
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b1);           // widest spread of two
        send_sample(16'h0007, 1'b0);
        send_sample(16'h0007, 1'b0);
        send_sample(16'h0007, 1'b1);           // equal samples
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0001, 1'b1);           // small spread, fraction bits
        for (int i = 0; i < 4; i++) send_sample(16'hAAAA ^ {16{i[0]}}, i == 3);
        drain();
    endtask

    task automatic test_random(int n_items);
        int left;
        int len;
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
            left -= len;
        end
    endtask

    task automatic test_pause();
        send_sample(16'h0100, 1'b0);
        send_sample(16'h0300, 1'b1);
        drain();                               // sender holds off until empty
        send_sample(16'h0005, 1'b1);
        drain();
    endtask

    initial begin
        errors = 0;
        set_sum = 0;
        set_count = 0;
        idle_pct = 0;
        start = 1'b0;
        i_sample = '0;
        i_last = 1'b0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        idle_pct = 21;
        test_random(130);
        test_pause();
        idle_pct = 83;
        test_random(110);
        idle_pct = 0;
        test_random(130);
        drain();
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("population_std_deviation_top_test passed");
        end else begin
            $display("population_std_deviation_top_test failed");
        end
        $finish;
    end

    // Timeout for up to about 400 one-sample sets.
    initial begin
        #8ms;
        $display("population_std_deviation_top_test failed");
        $finish;
    end
endmodule

>>> population_std_deviation_top.f
rtl/core/psd_pkg.sv
rtl/core/psd_fifo.sv
rtl/core/psd_div.sv
rtl/core/psd_back.sv
rtl/core/population_std_deviation_top.sv
tb/sv/population_std_deviation_top_test.sv
